/* rtl/lsp_pkg.sv */
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants and types of the line sensor position error unit.
// ----------------------------------------------------------------------------
package lsp_pkg;

  // Channel layout and fixed field widths
  localparam int unsigned CHANNELS       = 8;
  localparam int unsigned SLOT_BITS      = 16;
  localparam int unsigned CFG_BITS       = 64;
  localparam int unsigned CFG_IDX_BITS   = 3;
  localparam int unsigned THRESH_BITS    = 15;
  localparam int unsigned RATIO_BITS     = 16;
  localparam int unsigned ERROR_BITS     = 20;
  localparam int unsigned FIELD_BITS     = 16;

  // Default parameter values
  localparam int unsigned READING_BITS_DEF  = 16;
  localparam int unsigned FRACTION_BITS_DEF = 12;

  // Ratio saturation limits
  localparam logic signed [RATIO_BITS-1:0] RATIO_MAX = 16'sh7FFF;
  localparam logic signed [RATIO_BITS-1:0] RATIO_MIN = 16'sh8000;

  // Threshold reset values (0.2 and 0.5 in Q3.12)
  localparam logic [THRESH_BITS-1:0] WHITE_RESET = 15'd819;
  localparam logic [THRESH_BITS-1:0] BLACK_RESET = 15'd2048;

  // Register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_LOW   = 3'd0,
    REG_MIN_HIGH  = 3'd1,
    REG_MAX_LOW   = 3'd2,
    REG_MAX_HIGH  = 3'd3,
    REG_WHITE_THR = 3'd4,
    REG_BLACK_THR = 3'd5
  } reg_idx_e;

  // Scan classification
  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_WHITE = 2'd1,
    KIND_BLACK = 2'd2
  } kind_e;

  typedef logic signed [RATIO_BITS-1:0] ratio_t;

endpackage

/* rtl/lsp_lane.sv */
// ----------------------------------------------------------------------------
// lsp_lane
// One channel: normalises a reading against its calibration through a
// pipelined restoring divider, one quotient bit per stage, then saturates.
// ----------------------------------------------------------------------------
module lsp_lane #(
  parameter int unsigned READING_BITS  = lsp_pkg::READING_BITS_DEF,
  parameter int unsigned FRACTION_BITS = lsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic [READING_BITS-1:0] reading_i,
  input  logic [READING_BITS-1:0] min_i,
  input  logic [READING_BITS-1:0] max_i,
  output lsp_pkg::ratio_t         ratio_o
);

  localparam int unsigned RB = READING_BITS;
  localparam int unsigned QB = lsp_pkg::RATIO_BITS - 1;
  localparam int unsigned NW = RB + FRACTION_BITS;
  localparam int unsigned CW = RB + ((FRACTION_BITS > QB) ? FRACTION_BITS : QB) + 1;

  // Prepare: magnitude, divisor, special cases
  logic [RB-1:0] mag, den;
  logic          neg, degen, dzero, sat;
  logic [NW-1:0] num, num_hi;
  logic [CW-1:0] num_c, den_c;

  always_comb begin
    neg    = reading_i < min_i;
    mag    = neg ? (min_i - reading_i) : (reading_i - min_i);
    den    = max_i - min_i;
    degen  = max_i <= min_i;
    dzero  = reading_i == min_i;
    num    = {mag, {FRACTION_BITS{1'b0}}};
    num_hi = num >> QB;
    num_c  = CW'(num);
    den_c  = CW'({den, {QB{1'b0}}});
    sat    = num_c >= den_c;
  end

  // Divider stages
  logic [RB-1:0] rem_q   [0:QB];
  logic [QB-1:0] n_q     [0:QB];
  logic [QB-1:0] quo_q   [0:QB];
  logic [RB-1:0] den_q   [0:QB];
  logic          neg_q   [0:QB];
  logic          sat_q   [0:QB];
  logic          degen_q [0:QB];
  logic          dzero_q [0:QB];

  // Load the first stage
  always_ff @(posedge clk_i) begin
    rem_q[0]   <= num_hi[RB-1:0];
    n_q[0]     <= num[QB-1:0];
    quo_q[0]   <= '0;
    den_q[0]   <= den;
    neg_q[0]   <= neg;
    sat_q[0]   <= sat;
    degen_q[0] <= degen;
    dzero_q[0] <= dzero;
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [RB:0] trial, diff;
    logic        ge;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
      trial = {rem_q[k], n_q[k][QB-1]};
      diff  = trial - {1'b0, den_q[k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]   <= ge ? diff[RB-1:0] : trial[RB-1:0];
      n_q[k+1]     <= n_q[k] << 1;
      quo_q[k+1]   <= {quo_q[k][QB-2:0], ge};
      den_q[k+1]   <= den_q[k];
      neg_q[k+1]   <= neg_q[k];
      sat_q[k+1]   <= sat_q[k];
      degen_q[k+1] <= degen_q[k];
      dzero_q[k+1] <= dzero_q[k];
    end
  end

  // Apply sign, saturation and degenerate calibration
  lsp_pkg::ratio_t ratio_d, ratio_q, quo_s;

  always_comb begin
    quo_s = lsp_pkg::ratio_t'({1'b0, quo_q[QB]});
    if (degen_q[QB]) begin
      ratio_d = dzero_q[QB] ? '0 : lsp_pkg::RATIO_MAX;
    end else if (sat_q[QB]) begin
      ratio_d = neg_q[QB] ? lsp_pkg::RATIO_MIN : lsp_pkg::RATIO_MAX;
    end else begin
      ratio_d = neg_q[QB] ? -quo_s : quo_s;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q <= ratio_d;
  end

  assign ratio_o = ratio_q;

endmodule

/* rtl/lsp_merge.sv */
// ----------------------------------------------------------------------------
// lsp_merge
// Classifies the scan from all lane ratios and forms the weighted error.
// ----------------------------------------------------------------------------
module lsp_merge (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lsp_pkg::ratio_t                        ratio_i [lsp_pkg::CHANNELS],
  input  logic [lsp_pkg::THRESH_BITS-1:0]        white_thr_i,
  input  logic [lsp_pkg::THRESH_BITS-1:0]        black_thr_i,
  output lsp_pkg::kind_e                         kind_o,
  output logic signed [lsp_pkg::ERROR_BITS-1:0]  error_o,
  output lsp_pkg::ratio_t                        ratio_o [lsp_pkg::CHANNELS]
);

  localparam int unsigned NCH = lsp_pkg::CHANNELS;
  localparam int unsigned EW  = lsp_pkg::ERROR_BITS;

  lsp_pkg::ratio_t                  wt, bt;
  lsp_pkg::ratio_t                  clamp [NCH];
  lsp_pkg::ratio_t                  ratio_d [NCH];
  logic                             all_white, all_black;
  lsp_pkg::kind_e                   kind_d;
  logic signed [EW-1:0]             left, right, error_d;

  // Threshold compare, clamp and weighted sum
  always_comb begin
    wt        = lsp_pkg::ratio_t'({1'b0, white_thr_i});
    bt        = lsp_pkg::ratio_t'({1'b0, black_thr_i});
    all_white = 1'b1;
    all_black = 1'b1;
    for (int i = 0; i < NCH; i++) begin
      if (!(ratio_i[i] < wt)) all_white = 1'b0;
      if (!(ratio_i[i] > bt)) all_black = 1'b0;
      clamp[i] = ratio_i[i][lsp_pkg::RATIO_BITS-1] ? '0 : ratio_i[i];
    end
    left  = EW'(4) * EW'(clamp[0]) + EW'(3) * EW'(clamp[1]) +
            EW'(2) * EW'(clamp[2]) + EW'(clamp[3]);
    right = EW'(clamp[4]) + EW'(2) * EW'(clamp[5]) +
            EW'(3) * EW'(clamp[6]) + EW'(4) * EW'(clamp[7]);
    if (all_white) begin
      kind_d  = lsp_pkg::KIND_WHITE;
      error_d = '0;
      ratio_d = ratio_i;
    end else if (all_black) begin
      kind_d  = lsp_pkg::KIND_BLACK;
      error_d = '0;
      ratio_d = ratio_i;
    end else begin
      kind_d  = lsp_pkg::KIND_LINE;
      error_d = right - left;
      ratio_d = clamp;
    end
  end

  // Hold the result word
  lsp_pkg::kind_e       kind_q;
  logic signed [EW-1:0] error_q;
  lsp_pkg::ratio_t      ratio_q [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= lsp_pkg::KIND_LINE;
    end else begin
      kind_q <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    error_q <= error_d;
    ratio_q <= ratio_d;
  end

  assign kind_o  = kind_q;
  assign error_o = error_q;
  assign ratio_o = ratio_q;

endmodule

/* rtl/line_sensor_position_error_unit.sv */
// ----------------------------------------------------------------------------
// line_sensor_position_error_unit
// Eight-channel line sensor normaliser and weighted position error.
// ----------------------------------------------------------------------------
// A scan word is taken at every clock edge with start high (busy is always
// low), one scan per cycle. Its result appears on the outputs with done_o
// high for exactly one cycle: the per-channel dividers produce one quotient
// bit per pipeline stage (15 stages) plus a prepare and a saturate stage,
// followed by one merge stage. The receiver cannot stall the outputs.
// The user must write calibration registers through cfg_we_i / cfg_idx_i /
// cfg_wdata_i only while no scan is in flight; the unit does not enforce it.
module line_sensor_position_error_unit #(
  parameter int unsigned READING_BITS  = lsp_pkg::READING_BITS_DEF,
  parameter int unsigned FRACTION_BITS = lsp_pkg::FRACTION_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_0_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_1_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_2_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_3_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_4_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_5_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_6_i,
  input  logic [lsp_pkg::FIELD_BITS-1:0]        reading_7_i,
  input  logic                                  cfg_we_i,
  input  logic [lsp_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [lsp_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  output logic                                  done_o,
  output logic [1:0]                            kind_o,
  output logic signed [lsp_pkg::ERROR_BITS-1:0] position_error_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_0_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_1_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_2_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_3_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_4_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_5_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_6_o,
  output logic signed [lsp_pkg::RATIO_BITS-1:0] ratio_7_o
);

  localparam int unsigned NCH      = lsp_pkg::CHANNELS;
  localparam int unsigned HALF     = NCH / 2;
  localparam int unsigned SB       = lsp_pkg::SLOT_BITS;
  localparam int unsigned LANE_LAT = lsp_pkg::RATIO_BITS + 1;

  logic accept;
  assign accept = start && !busy;
  assign busy   = 1'b0;

  // Calibration registers
  logic [lsp_pkg::CFG_BITS-1:0]    min_lo_q, min_hi_q, max_lo_q, max_hi_q;
  logic [lsp_pkg::THRESH_BITS-1:0] white_q, black_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lo_q <= '0;
      min_hi_q <= '0;
      max_lo_q <= '1;
      max_hi_q <= '1;
      white_q  <= lsp_pkg::WHITE_RESET;
      black_q  <= lsp_pkg::BLACK_RESET;
    end else if (cfg_we_i) begin
      case (lsp_pkg::reg_idx_e'(cfg_idx_i))
        lsp_pkg::REG_MIN_LOW:   min_lo_q <= cfg_wdata_i;
        lsp_pkg::REG_MIN_HIGH:  min_hi_q <= cfg_wdata_i;
        lsp_pkg::REG_MAX_LOW:   max_lo_q <= cfg_wdata_i;
        lsp_pkg::REG_MAX_HIGH:  max_hi_q <= cfg_wdata_i;
        lsp_pkg::REG_WHITE_THR: white_q  <= cfg_wdata_i[lsp_pkg::THRESH_BITS-1:0];
        lsp_pkg::REG_BLACK_THR: black_q  <= cfg_wdata_i[lsp_pkg::THRESH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Gather readings into an array
  logic [lsp_pkg::FIELD_BITS-1:0] reading [NCH];
  assign reading[0] = reading_0_i;
  assign reading[1] = reading_1_i;
  assign reading[2] = reading_2_i;
  assign reading[3] = reading_3_i;
  assign reading[4] = reading_4_i;
  assign reading[5] = reading_5_i;
  assign reading[6] = reading_6_i;
  assign reading[7] = reading_7_i;

  // Per-channel lanes
  lsp_pkg::ratio_t lane_ratio [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    logic [lsp_pkg::CFG_BITS-1:0] min_w, max_w;
    assign min_w = (c < HALF) ? min_lo_q : min_hi_q;
    assign max_w = (c < HALF) ? max_lo_q : max_hi_q;

    lsp_lane #(
      .READING_BITS  (READING_BITS),
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk_i     (clk_i),
      .reading_i (reading[c][READING_BITS-1:0]),
      .min_i     (min_w[SB*(c%HALF) +: READING_BITS]),
      .max_i     (max_w[SB*(c%HALF) +: READING_BITS]),
      .ratio_o   (lane_ratio[c])
    );
  end

  // Track words through the lane pipeline
  logic [LANE_LAT-1:0] vld_q;
  logic                done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[LANE_LAT-2:0], accept};
      done_q <= vld_q[LANE_LAT-1];
    end
  end

  // Merge lanes into the result word
  lsp_pkg::kind_e  kind;
  lsp_pkg::ratio_t out_ratio [NCH];

  lsp_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ratio_i     (lane_ratio),
    .white_thr_i (white_q),
    .black_thr_i (black_q),
    .kind_o      (kind),
    .error_o     (position_error_o),
    .ratio_o     (out_ratio)
  );

  assign done_o    = done_q;
  assign kind_o    = kind;
  assign ratio_0_o = out_ratio[0];
  assign ratio_1_o = out_ratio[1];
  assign ratio_2_o = out_ratio[2];
  assign ratio_3_o = out_ratio[3];
  assign ratio_4_o = out_ratio[4];
  assign ratio_5_o = out_ratio[5];
  assign ratio_6_o = out_ratio[6];
  assign ratio_7_o = out_ratio[7];

  // Every accepted word is followed by done_o after the lane and merge stages
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(LANE_LAT + 1) done_o)
    else $error("accepted word did not complete on time");

  // No error outside a seen line
  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind != lsp_pkg::KIND_LINE) |-> position_error_o == '0)
    else $error("non-zero error for all-white or all-black scan");

  // Ratios are clamped when a line is seen
  a_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind == lsp_pkg::KIND_LINE) |->
      !ratio_0_o[15] && !ratio_1_o[15] && !ratio_2_o[15] && !ratio_3_o[15] &&
      !ratio_4_o[15] && !ratio_5_o[15] && !ratio_6_o[15] && !ratio_7_o[15])
    else $error("negative ratio left unclamped");

endmodule

/* bench/line_sensor_position_error_unit_tb.sv */
// ----------------------------------------------------------------------------
// line_sensor_position_error_unit_tb
// Drives scans through the line sensor unit under several calibrations and
// checks every result word against a behavioural predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module line_sensor_position_error_unit_tb;

  localparam int unsigned LATENCY = 18;

  typedef struct {
    logic [1:0]         kind;
    logic signed [19:0] err;
    logic signed [15:0] ratio [8];
  } scan_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] reading [8];
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [1:0]  kind_o;
  logic signed [19:0] position_error_o;
  logic signed [15:0] ratio_o [8];

  // Model copy of the calibration registers
  logic [63:0] cal_min_lo, cal_min_hi, cal_max_lo, cal_max_hi;
  logic [14:0] white_thr, black_thr;

  scan_result_t pending_results [$];
  int  error_count = 0;
  bit  quiet = 1'b0;

  initial foreach (reading[i]) reading[i] = '0;

  line_sensor_position_error_unit u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .reading_0_i(reading[0]), .reading_1_i(reading[1]),
    .reading_2_i(reading[2]), .reading_3_i(reading[3]),
    .reading_4_i(reading[4]), .reading_5_i(reading[5]),
    .reading_6_i(reading[6]), .reading_7_i(reading[7]),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .done_o, .kind_o, .position_error_o,
    .ratio_0_o(ratio_o[0]), .ratio_1_o(ratio_o[1]),
    .ratio_2_o(ratio_o[2]), .ratio_3_o(ratio_o[3]),
    .ratio_4_o(ratio_o[4]), .ratio_5_o(ratio_o[5]),
    .ratio_6_o(ratio_o[6]), .ratio_7_o(ratio_o[7])
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Normalise one reading against its calibration
  function automatic logic signed [15:0] normalise(logic [15:0] rd, logic [15:0] lo,
                                                    logic [15:0] hi);
    longint num, den, q;
    if (hi <= lo) return (rd == lo) ? 16'sd0 : lsp_pkg::RATIO_MAX;
    num = (longint'(rd) - longint'(lo)) * 4096;
    den = longint'(hi) - longint'(lo);
    q = num / den;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic scan_result_t scan_position(logic [15:0] rd [8]);
    scan_result_t res;
    bit all_white = 1, all_black = 1;
    int r [8];
    int e;
    logic [63:0] lo_w, hi_w;
    for (int i = 0; i < 8; i++) begin
      lo_w = (i < 4) ? cal_min_lo : cal_min_hi;
      hi_w = (i < 4) ? cal_max_lo : cal_max_hi;
      r[i] = normalise(rd[i], lo_w[16*(i%4) +: 16], hi_w[16*(i%4) +: 16]);
      if (!(r[i] < int'(white_thr))) all_white = 0;
      if (!(r[i] > int'(black_thr))) all_black = 0;
    end
    e = 0;
    if (all_white) res.kind = lsp_pkg::KIND_WHITE;
    else if (all_black) res.kind = lsp_pkg::KIND_BLACK;
    else begin
      res.kind = lsp_pkg::KIND_LINE;
      foreach (r[i]) if (r[i] < 0) r[i] = 0;
      e = (r[4] + 2*r[5] + 3*r[6] + 4*r[7]) - (4*r[0] + 3*r[1] + 2*r[2] + r[3]);
    end
    res.err = e[19:0];
    foreach (r[i]) res.ratio[i] = r[i][15:0];
    return res;
  endfunction

  // Drive one register at a falling edge and mirror it in the model
  task automatic write_reg(lsp_pkg::reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      lsp_pkg::REG_MIN_LOW:   cal_min_lo = val;
      lsp_pkg::REG_MIN_HIGH:  cal_min_hi = val;
      lsp_pkg::REG_MAX_LOW:   cal_max_lo = val;
      lsp_pkg::REG_MAX_HIGH:  cal_max_hi = val;
      lsp_pkg::REG_WHITE_THR: white_thr = val[14:0];
      lsp_pkg::REG_BLACK_THR: black_thr = val[14:0];
      default: ;
    endcase
  endtask

  task automatic calibrate(logic [63:0] mnl, mnh, mxl, mxh, logic [14:0] w, b);
    write_reg(lsp_pkg::REG_MIN_LOW, mnl);
    write_reg(lsp_pkg::REG_MIN_HIGH, mnh);
    write_reg(lsp_pkg::REG_MAX_LOW, mxl);
    write_reg(lsp_pkg::REG_MAX_HIGH, mxh);
    write_reg(lsp_pkg::REG_WHITE_THR, {49'(0), w});
    write_reg(lsp_pkg::REG_BLACK_THR, {49'(0), b});
  endtask

  // Send one scan word; start stays high across back-to-back words
  task automatic send_scan(logic [15:0] rd [8]);
    if (!quiet && $urandom_range(99) < 11) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    start = 1'b1;
    reading = rd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_results.push_back(scan_position(rd));
    @(negedge clk_i);
  endtask

  task automatic drain;
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    scan_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word kind %0d", $time, kind_o);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (kind_o !== exp_res.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, exp_res.kind, kind_o);
          error_count++;
        end
        if (position_error_o !== exp_res.err) begin
          $display("%0t: error expected %0d actual %0d", $time, exp_res.err,
                   position_error_o);
          error_count++;
        end
        for (int i = 0; i < 8; i++)
          if (ratio_o[i] !== exp_res.ratio[i]) begin
            $display("%0t: ratio_%0d expected %0d actual %0d", $time, i,
                     exp_res.ratio[i], ratio_o[i]);
            error_count++;
          end
      end
    end
  end

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  task automatic test_extremes;
    logic [15:0] rd [8];
    foreach (rd[i]) rd[i] = 16'h0000; send_scan(rd);
    foreach (rd[i]) rd[i] = 16'hFFFF; send_scan(rd);
    foreach (rd[i]) rd[i] = (i < 4) ? 16'hFFFF : 16'h0000; send_scan(rd);
    foreach (rd[i]) rd[i] = (i < 4) ? 16'h0000 : 16'hFFFF; send_scan(rd);
    foreach (rd[i]) rd[i] = 16'h8000 >> i; send_scan(rd);
    foreach (rd[i]) rd[i] = 16'hAAAA ^ {16{i[0]}}; send_scan(rd);
    drain();
  endtask

  // Narrow spans, degenerate channels and readings below the minimum
  task automatic test_degenerate;
    logic [15:0] rd [8];
    calibrate(64'h1000_1000_1000_1000, 64'h2000_2000_0010_FFFF,
              64'h1000_0FFF_1001_FFFF, 64'h2001_1FFF_0011_FFFF, 15'd819, 15'd2048);
    foreach (rd[i]) rd[i] = 16'h1000; send_scan(rd);
    rd = '{16'h0000, 16'h1000, 16'h1001, 16'h0000, 16'hFFFF, 16'h2000, 16'h0000,
           16'hFFFF};
    send_scan(rd);
    rd = '{16'hFFFF, 16'h0FFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0011,
           16'hFFFE};
    send_scan(rd);
    drain();
    calibrate(64'h0100_0100_0100_0100, 64'h0100_0100_0100_0100,
              64'h0200_0200_0200_0200, 64'h0200_0200_0200_0200, 15'h7FFF, 15'h0000);
    rd = '{16'h0000, 16'h0050, 16'h0100, 16'h0180, 16'h0200, 16'h0400, 16'h00FF,
           16'h0101};
    send_scan(rd);
    foreach (rd[i]) rd[i] = 16'h0180; send_scan(rd);
    drain();
    calibrate(64'h0100_0100_0100_0100, 64'h0100_0100_0100_0100,
              64'h0200_0200_0200_0200, 64'h0200_0200_0200_0200, 15'h0000, 15'h7FFF);
    foreach (rd[i]) rd[i] = 16'h0180; send_scan(rd);
    foreach (rd[i]) rd[i] = 16'h0000; send_scan(rd);
    drain();
  endtask

  // Random scans under four calibrations, readings mostly within the span
  task automatic test_random(int count);
    logic [15:0] rd [8];
    logic [63:0] mn [2], mx [2];
    logic [15:0] lo, hi;
    int span;
    for (int p = 0; p < 4; p++) begin
      for (int h = 0; h < 2; h++)
        for (int c = 0; c < 4; c++) begin
          lo = 16'($urandom_range(0, 2000));
          hi = lo + 16'($urandom_range(1, 4000));
          if ($urandom_range(15) == 0) hi = lo - 16'($urandom_range(0, 3));
          mn[h][16*c +: 16] = lo;
          mx[h][16*c +: 16] = hi;
        end
      if (p == 3) begin
        mn[0] = 64'h0; mn[1] = 64'h0; mx[0] = '1; mx[1] = '1;
      end
      calibrate(mn[0], mn[1], mx[0], mx[1], 15'($urandom_range(100, 1500)),
                15'($urandom_range(1500, 4000)));
      quiet = (p == 1);
      for (int n = 0; n < count / 4; n++) begin
        for (int i = 0; i < 8; i++) begin
          lo = (i < 4) ? mn[0][16*i +: 16] : mn[1][16*(i-4) +: 16];
          hi = (i < 4) ? mx[0][16*i +: 16] : mx[1][16*(i-4) +: 16];
          span = (hi > lo) ? hi - lo : 1;
          case ($urandom_range(9))
            0: rd[i] = rand16();
            1, 2: rd[i] = lo + 16'($urandom_range(0, span / 6));
            3, 4: rd[i] = hi - 16'($urandom_range(0, span / 3));
            default: rd[i] = lo + 16'($urandom_range(0, span));
          endcase
        end
        // Whole-scan white now and then
        if ($urandom_range(9) == 0) foreach (rd[i]) rd[i] = (i < 4) ?
          mn[0][16*i +: 16] : mn[1][16*(i-4) +: 16];
        send_scan(rd);
      end
      quiet = 1'b0;
      drain();
    end
  endtask

  initial begin
    cal_min_lo = '0; cal_min_hi = '0; cal_max_lo = '1; cal_max_hi = '1;
    white_thr = lsp_pkg::WHITE_RESET; black_thr = lsp_pkg::BLACK_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_degenerate();
    test_random(1000);
    if (error_count == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* files.f */
rtl/lsp_pkg.sv
rtl/lsp_lane.sv
rtl/lsp_merge.sv
rtl/line_sensor_position_error_unit.sv
bench/line_sensor_position_error_unit_tb.sv
